@@ rtl/mf2d_pkg.sv @@
// Shared types and constants for the minifloat to binary64 decoder.
package mf2d_pkg;

	typedef enum logic [2:0] {
		KIND_ZERO   = 3'd0,
		KIND_SUB    = 3'd1,
		KIND_INF    = 3'd2,
		KIND_NAN    = 3'd3,
		KIND_NORMAL = 3'd4,
		KIND_BAD    = 3'd5
	} kind_t;

	localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;
	localparam logic [10:0] F64_EXP_ALL = 11'h7FF;
	localparam int unsigned F64_FRAC_BITS = 52;
	localparam logic [3:0] EXP_BITS_MIN = 4'd2;
	localparam logic [3:0] EXP_BITS_MAX = 4'd11;
	localparam logic [5:0] MAN_BITS_MIN = 6'd1;
	localparam logic [5:0] MAN_BITS_MAX = 6'd52;

	typedef struct packed {
		logic [2:0]  kind;
		logic        sign;
		logic [63:0] value_bits;
	} mf2d_res_t;

endpackage

@@ rtl/mf2d_if.sv @@
// Valid/ready channel interface used on both sides of the decoder.
interface mf2d_if #(
	parameter int unsigned W = 8
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/minifloat_to_binary64_core.sv @@
// Top level: registered single-pass minifloat to binary64 decoder.
//  channel | dir | payload
//  in_ch   | in  | exp_bits[3:0], man_bits[5:0], pattern[PATTERN_WIDTH-1:0]
//  out_ch  | out | kind[2:0], sign, value_bits[63:0]
// One beat per cycle sustained while out_ch is ready; the result is valid in the cycle after input accept.
// The decode sits between the input handshake and one result register.
// Reset clears only the result valid flag; payload is not reset.
// A stalled result holds; in_ch ready follows out_ch ready when full.
module minifloat_to_binary64_core
	import mf2d_pkg::*;
#(
	parameter int unsigned PATTERN_WIDTH = 64
) (
	input logic clk,
	input logic arst_n,
	mf2d_if.sink   in_ch,
	mf2d_if.source out_ch
);
	logic [3:0]               exp_bits;
	logic [5:0]               man_bits;
	logic [PATTERN_WIDTH-1:0] pattern;
	mf2d_res_t                res;
	mf2d_res_t                res_q;
	logic                     vld_q;
	logic                     in_fire;

	// input data: {exp_bits, man_bits, pattern}
	assign {exp_bits, man_bits, pattern} = in_ch.data;

	mf2d_decode #(.PATTERN_WIDTH(PATTERN_WIDTH)) u_dec (
		.exp_bits(exp_bits), .man_bits(man_bits), .pattern(pattern), .res(res)
	);

	// accept whenever the result register is empty or drains this cycle
	assign in_ch.ready = !vld_q || out_ch.ready;
	assign in_fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ch.ready) begin
			vld_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = vld_q;
	assign out_ch.data = res_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !out_ch.ready |=> vld_q && $stable(res_q))
		else $error("result changed while stalled");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> vld_q)
		else $error("accepted beat lost");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && res_q.kind == KIND_NAN |-> res_q.value_bits == F64_QNAN)
		else $error("nan not canonical");
endmodule

@@ rtl/mf2d_decode.sv @@
// Combinational classification and binary64 packing of one pattern.
module mf2d_decode
	import mf2d_pkg::*;
#(
	parameter int unsigned PATTERN_WIDTH = 64
) (
	input  logic [3:0]               exp_bits,
	input  logic [5:0]               man_bits,
	input  logic [PATTERN_WIDTH-1:0] pattern,
	output mf2d_res_t                res
);
	logic [63:0] pat;
	logic [6:0]  total;
	logic        bad;
	logic [10:0] emax;
	logic [10:0] expf;
	logic [63:0] fmask;
	logic [51:0] frac;
	logic [10:0] bias;
	logic        sgn;
	logic [5:0]  p;
	logic        found;
	logic [51:0] rest;
	logic [12:0] e_sub;
	logic [12:0] sh_raw;
	logic [5:0]  sh;
	logic [10:0] exp_norm;
	logic [63:0] shifted;

	always_comb begin
		pat = 64'(pattern);
		total = 7'(exp_bits) + 7'(man_bits);
		bad = (exp_bits < EXP_BITS_MIN) || (exp_bits > EXP_BITS_MAX) ||
			(man_bits < MAN_BITS_MIN) || (man_bits > MAN_BITS_MAX) ||
			((32'(total) + 32'd1) > 32'(PATTERN_WIDTH));
		emax = 11'((12'd1 << exp_bits) - 12'd1);
		expf = 11'(pat >> man_bits) & emax;
		fmask = (64'd1 << man_bits) - 64'd1;
		frac = 52'(pat & fmask);
		bias = 11'((12'd1 << (exp_bits - 4'd1)) - 12'd1);
		sgn = pat[total[5:0]];
		// leading one search, priority from the top
		p = 6'd0;
		found = 1'b0;
		for (int i = 51; i >= 0; i--) begin
			if (!found && frac[i]) begin
				p = 6'(i);
				found = 1'b1;
			end
		end
		rest = frac ^ (52'd1 << p);
		// biased exponent of a subnormal: p+1-bias-mbits+1023
		e_sub = 13'(p) + 13'd1024 - 13'(bias) - 13'(man_bits);
		sh_raw = 13'd1075 - 13'(bias) - 13'(man_bits);
		sh = (sh_raw > 13'd63) ? 6'd63 : sh_raw[5:0];
		exp_norm = expf - bias + 11'd1023;
		shifted = 64'(frac) << (6'd52 - man_bits);
		res = '{kind: KIND_BAD, sign: 1'b0, value_bits: 64'd0};
		if (!bad) begin
			res.sign = sgn;
			if (expf == emax) begin
				if (frac != 52'd0) begin
					res.kind = KIND_NAN;
					res.value_bits = F64_QNAN;
				end else begin
					res.kind = KIND_INF;
					res.value_bits = {sgn, F64_EXP_ALL, 52'd0};
				end
			end else if (expf == 11'd0) begin
				if (frac == 52'd0) begin
					res.kind = KIND_ZERO;
					res.value_bits = {sgn, 63'd0};
				end else begin
					res.kind = KIND_SUB;
					// wide exponents can drive e_sub to zero or below: binary64 subnormal
					res.value_bits = {sgn, e_sub[10:0], 52'(rest << (6'd52 - p))};
					if (e_sub[12] || e_sub == 13'd0)
						res.value_bits = {sgn, 11'd0, 52'(64'(frac) << sh)};
				end
			end else begin
				res.kind = KIND_NORMAL;
				res.value_bits = {sgn, exp_norm, shifted[51:0]};
			end
		end
	end
endmodule

@@ tb/mf2d_checker.sv @@
// Checker: predicts decoded results from accepted input beats and compares outputs.
module mf2d_checker
	import mf2d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [73:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [67:0] out_data,
	output int          fail_count,
	output int          pending
);

	mf2d_res_t expected_q[$];

	function automatic mf2d_res_t decode_minifloat(logic [3:0] eb, logic [5:0] mb,
			logic [63:0] pat);
		mf2d_res_t r;
		int unsigned total;
		logic [63:0] emax, expf, frac;
		int bias, p, e, sh;
		r = '0;
		if (eb < EXP_BITS_MIN || eb > EXP_BITS_MAX || mb < MAN_BITS_MIN ||
				mb > MAN_BITS_MAX || eb + mb + 1 > 64) begin
			r.kind = KIND_BAD;
			return r;
		end
		total = eb + mb;
		emax = (64'd1 << eb) - 1;
		expf = (pat >> mb) & emax;
		frac = pat & ((64'd1 << mb) - 1);
		bias = (1 << (eb - 1)) - 1;
		r.sign = pat[total];
		if (expf == emax) begin
			if (frac != 0) begin
				r.kind = KIND_NAN;
				r.value_bits = F64_QNAN;
			end else begin
				r.kind = KIND_INF;
				r.value_bits = {r.sign, F64_EXP_ALL, 52'd0};
			end
		end else if (expf == 0) begin
			if (frac == 0) begin
				r.kind = KIND_ZERO;
				r.value_bits = {r.sign, 63'd0};
			end else begin
				r.kind = KIND_SUB;
				p = mb - 1;
				while (p > 0 && frac[p] == 1'b0)
					p--;
				e = p + 1 - bias - int'(mb);
				if (e >= -1022) begin
					r.value_bits = {r.sign, 11'(e + 1023),
						52'((frac ^ (64'd1 << p)) << (52 - p))};
				end else begin
					// far subnormal sources map to binary64 subnormals
					sh = 1075 - bias - int'(mb);
					if (sh < 0) sh = 0;
					if (sh > 63) sh = 63;
					r.value_bits = {r.sign, 11'd0, 52'(frac << sh)};
				end
			end
		end else begin
			r.kind = KIND_NORMAL;
			r.value_bits = {r.sign, 11'(int'(expf) - bias + 1023),
				52'(frac << (52 - mb))};
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = expected_q.size();

	always @(posedge clk) begin
		mf2d_res_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected beat", got.value_bits, 64'd0);
				end else begin
					want = expected_q.pop_front();
					if (got.kind !== want.kind)
						report_mismatch("kind", 64'(got.kind), 64'(want.kind));
					if (got.sign !== want.sign)
						report_mismatch("sign", 64'(got.sign), 64'(want.sign));
					if (got.value_bits !== want.value_bits)
						report_mismatch("value_bits", got.value_bits, want.value_bits);
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(decode_minifloat(in_data[73:70], in_data[69:64],
					in_data[63:0]));
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: stimulus, idling phases, back-pressure and verdict.
module tb_top
	import mf2d_pkg::*;
();

	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	int   fail_count, pending;
	int   send_idle_pct, recv_stall_pct;
	bit   hold_off;
	bit   done_sending;
	int   quiet_cycles;

	mf2d_if #(.W(74)) in_ch ();
	mf2d_if #(.W(68)) out_ch ();

	minifloat_to_binary64_core u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	mf2d_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_data   (in_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Reset once; all inputs known from time zero.
	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// Receiver: random stalls per phase, plus a long hold-off window.
	always @(posedge clk) begin
		if (arst_n)
			out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one beat and hold it until accepted; gap chance from the phase.
	task automatic send_beat(logic [3:0] eb, logic [5:0] mb, logic [63:0] pat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= {eb, mb, pat};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Pattern biased toward exponent all-ones / all-zeros and tiny fractions.
	function automatic logic [63:0] shaped_pattern(logic [3:0] eb, logic [5:0] mb);
		logic [63:0] pat, emask;
		int sel;
		pat = {$urandom, $urandom};
		emask = ((64'd1 << eb) - 1) << mb;
		sel = $urandom_range(7);
		if (sel == 0) pat = pat | emask;
		else if (sel == 1) pat = pat & ~emask;
		else if (sel == 2) pat = (pat & ~((64'd1 << mb) - 1)) | emask;
		else if (sel == 3) pat = (pat & ~emask) & ~((64'd1 << mb) - 1) |
			(64'd1 << $urandom_range(mb - 1));
		else if (sel == 4) pat = pat & ~((64'd1 << mb) - 1);
		return pat;
	endfunction

	task automatic random_beats(int n);
		logic [3:0] eb;
		logic [5:0] mb;
		repeat (n) begin
			if ($urandom_range(19) == 0) begin
				// malformed sizes, including out-of-range codes
				eb = 4'($urandom);
				mb = 6'($urandom);
			end else begin
				eb = 4'($urandom_range(EXP_BITS_MAX, EXP_BITS_MIN));
				mb = ($urandom_range(3) == 0) ?
					6'($urandom_range(MAN_BITS_MAX, MAN_BITS_MIN)) :
					6'($urandom_range(MAN_BITS_MAX, 64 - 1 - eb - 8 > 0 ?
					MAN_BITS_MAX - 8 : MAN_BITS_MIN));
			end
			send_beat(eb, mb, shaped_pattern(eb, mb));
		end
	endtask

	initial begin
		hold_off = 0;
		done_sending = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: each class, extreme sizes, sign handling, bad formats
		send_beat(4'd2, 6'd1, 64'h0);
		send_beat(4'd2, 6'd1, 64'h8);
		send_beat(4'd2, 6'd1, 64'h1);
		send_beat(4'd2, 6'd1, 64'h6);
		send_beat(4'd2, 6'd1, 64'h7);
		send_beat(4'd2, 6'd1, 64'hE);
		send_beat(4'd11, 6'd52, 64'h0000_0000_0000_0001);
		send_beat(4'd11, 6'd52, 64'h8008_0000_0000_0000);
		send_beat(4'd11, 6'd52, 64'hFFF0_0000_0000_0000);
		send_beat(4'd11, 6'd52, 64'h7FFF_FFFF_FFFF_FFFF);
		send_beat(4'd11, 6'd52, 64'h3FF0_0000_0000_0000);
		send_beat(4'd11, 6'd52, 64'hFFEF_FFFF_FFFF_FFFF);
		send_beat(4'd11, 6'd51, 64'hFFFF_0000_0000_0001);
		send_beat(4'd8, 6'd23, 64'hFFFF_FFFF_8000_0000);
		send_beat(4'd5, 6'd10, 64'h0000_0000_0000_03FF);
		send_beat(4'd11, 6'd52, {$urandom, $urandom});
		send_beat(4'd1, 6'd10, 64'h5);
		send_beat(4'd12, 6'd10, 64'h5);
		send_beat(4'd15, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(4'd4, 6'd0, 64'h5);
		send_beat(4'd4, 6'd53, 64'h5);
		send_beat(4'd2, 6'd1, 64'hFFFF_FFFF_FFFF_FFF9);
		// random phases: none, sender idle, receiver stall, both
		random_beats(400);
		send_idle_pct = 61;
		random_beats(400);
		send_idle_pct = 0;
		recv_stall_pct = 61;
		random_beats(400);
		send_idle_pct = 9;
		recv_stall_pct = 9;
		random_beats(400);
		// long receiver hold-off while the sender keeps offering
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			random_beats(50);
		join
		in_ch.valid <= 0;
		done_sending = 1;
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
